### design/utaf_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII formatter.
package utaf_pkg;

  typedef enum logic [1:0] {
    OP_DEC  = 2'd0,
    OP_HEXL = 2'd1,
    OP_HEXU = 2'd2,
    OP_PTR  = 2'd3
  } op_t;

  localparam int BIN_BITS   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_BITS   = 4 * BCD_DIGITS;
  localparam int ITER_W     = $clog2(BIN_BITS);
  localparam int DREG_BITS  = 64;
  localparam int NIB_MAX    = DREG_BITS / 4;
  localparam int CNT_W      = $clog2(NIB_MAX + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPPA  = 8'h41;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UPPA : CH_LOWA;
      if (nib < 4'd10) begin
        digit_char = CH_ZERO + {4'd0, nib};
      end else begin
        digit_char = base + {4'd0, nib} - 8'd10;
      end
    end
  endfunction

endpackage

### design/utaf_bcd.sv
// Iterative binary-to-BCD converter: one shift-and-adjust step per cycle.
module utaf_bcd
  import utaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [BIN_BITS-1:0] bin,
  output logic                done,
  output logic [BCD_BITS-1:0] bcd
);

  logic                busy;
  logic [ITER_W-1:0]   iter;
  logic [BIN_BITS-1:0] sh;
  logic [BCD_BITS-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        sh   <= bin;
        bcd  <= '0;
      end else if (busy) begin
        bcd  <= {adj[BCD_BITS-2:0], sh[BIN_BITS-1]};
        sh   <= {sh[BIN_BITS-2:0], 1'b0};
        iter <= iter + 1'b1;
        if (iter == ITER_W'(BIN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/unsigned_to_ascii_formatter.sv
// Unsigned number to ASCII text formatter: one character per output transaction,
// most significant digit first, no leading zeros. Decimal first runs through the
// shift-and-add-3 BCD unit (32 shift steps, then a handoff to normalisation);
// every operation then drops leading zero digits one at a time (up to 9
// decimal, 7 for 32-bit hex, 15 for 64-bit hex), then emits the characters
// (1 to 10, 1 to 8, or 3 to 18 with the "0x" prefix), holding while the
// output is stalled. The input is ready again once the last character
// is loaded.
module unsigned_to_ascii_formatter
  import utaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [1:0] operation, [65:2] value, [71:66] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast    // last_char
);

  typedef enum logic [2:0] {
    S_IDLE, S_BCD, S_NORM, S_PRE0, S_PREX, S_EMIT
  } state_t;

  state_t               state;
  op_t                  op;
  logic [DREG_BITS-1:0] dreg;
  logic [CNT_W-1:0]     cnt;
  logic                 bcd_start;
  logic                 bcd_done;
  logic [BCD_BITS-1:0]  bcd;
  logic                 out_free;
  logic                 out_load;
  op_t                  in_op;

  assign in_op     = op_t'(s_tdata[1:0]);
  assign s_tready  = (state == S_IDLE);
  assign bcd_start = s_tready && s_tvalid && (in_op == OP_DEC);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == S_PRE0 || state == S_PREX || state == S_EMIT);

  utaf_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .bin   (s_tdata[BIN_BITS+1:2]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= in_op;
            if (in_op == OP_DEC) begin
              state <= S_BCD;
            end else if (in_op == OP_PTR) begin
              dreg  <= s_tdata[DREG_BITS+1:2];
              cnt   <= CNT_W'(NIB_MAX);
              state <= S_NORM;
            end else begin
              dreg  <= {s_tdata[BIN_BITS+1:2], {(DREG_BITS-BIN_BITS){1'b0}}};
              cnt   <= CNT_W'(BIN_BITS / 4);
              state <= S_NORM;
            end
          end
        end
        S_BCD: begin
          if (bcd_done) begin
            dreg  <= {bcd, {(DREG_BITS-BCD_BITS){1'b0}}};
            cnt   <= CNT_W'(BCD_DIGITS);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // drop one leading zero digit a cycle, keep at least one
          if (dreg[DREG_BITS-1 -: 4] == 4'd0 && cnt > CNT_W'(1)) begin
            dreg <= {dreg[DREG_BITS-5:0], 4'd0};
            cnt  <= cnt - 1'b1;
          end else begin
            state <= (op == OP_PTR) ? S_PRE0 : S_EMIT;
          end
        end
        S_PRE0: begin
          if (out_free) begin
            m_tdata  <= CH_ZERO;
            m_tlast  <= 1'b0;
            state    <= S_PREX;
          end
        end
        S_PREX: begin
          if (out_free) begin
            m_tdata  <= CH_X;
            m_tlast  <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= digit_char(dreg[DREG_BITS-1 -: 4], op == OP_HEXU);
            m_tlast  <= (cnt == CNT_W'(1));
            dreg     <= {dreg[DREG_BITS-5:0], 4'd0};
            cnt      <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/utaf_check.sv
// Port-level checker for the formatter, bound to the top level.
module utaf_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [71:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // an accepted number keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // while characters remain, no new number is taken
  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready with text still pending");

  // only digits, letters and the prefix characters come out
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'h3) || (m_tdata[7:4] == 4'h4) ||
                 (m_tdata[7:4] == 4'h6) || (m_tdata[7:4] == 4'h7))
    else $error("character outside the formatted set");

endmodule

bind unsigned_to_ascii_formatter utaf_check u_check (.*);
